// File: src/vn2h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2h_pkg: shared types and constants of the 2-D value-noise height sampler
// Hash mixer constants, lattice offsets, field widths and register indexes.
// ----------------------------------------------------------------------------
package vn2h_pkg;

  // field widths
  localparam int CoordW   = 32;
  localparam int FreqW    = 24;
  localparam int AmpW     = 31;
  localparam int HeightW  = 32;
  localparam int WeightW  = 16;
  localparam int CornerW  = 24;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  // hash mixer and lattice offsets
  localparam logic [31:0] MixA       = 32'h7feb352d;
  localparam logic [31:0] MixB       = 32'h846ca68b;
  localparam logic [31:0] OfsX       = 32'h9e3779b9;
  localparam logic [31:0] OfsZ       = 32'h85ebca6b;
  localparam logic [31:0] Low24      = 32'h00ffffff;
  localparam logic [31:0] CornerBias = 32'h00800000;

  // smoothstep constant 3 * 2^16
  localparam logic [17:0] SmoothK = 18'd196608;

  // register reset values
  localparam logic [31:0] SeedRst = 32'd1337;
  localparam logic [23:0] FreqRst = 24'd5571;
  localparam logic [31:0] BaseRst = 32'd327680;
  localparam logic [30:0] AmpRst  = 31'd851968;

  // saturation bounds
  localparam logic [HeightW-1:0] HeightMax = 32'h7fffffff;
  localparam logic [HeightW-1:0] HeightMin = 32'h80000000;

  // register indexes
  typedef enum logic [1:0] {
    RegSeed = 2'd0,
    RegFreq = 2'd1,
    RegBase = 2'd2,
    RegAmp  = 2'd3
  } reg_idx_e;

  // four corner values, Q1.23 each
  typedef struct packed {
    logic [CornerW-1:0] c00;
    logic [CornerW-1:0] c10;
    logic [CornerW-1:0] c01;
    logic [CornerW-1:0] c11;
  } corners_t;

  // xor-shift steps of the mixer
  function automatic logic [31:0] xs16(input logic [31:0] x);
    return x ^ (x >> 16);
  endfunction

  function automatic logic [31:0] xs15(input logic [31:0] x);
    return x ^ (x >> 15);
  endfunction

  // low 24 hash bits re-centered around zero
  function automatic logic [CornerW-1:0] corner_val(input logic [31:0] h);
    logic [31:0] m;
    m = (h & Low24) - CornerBias;
    return m[CornerW-1:0];
  endfunction

endpackage

// File: src/value_noise_2d_height.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_height: 2-D value-noise terrain height sampler
// Seeded lattice hash, smoothstep bilinear interpolation, amplitude scaling.
// ----------------------------------------------------------------------------
// Usage:
//   A coordinate beat (pos_x_i, pos_z_i) is taken at each clock edge where
//   start is high; busy stays low, so one coordinate enters every cycle.
//   Each beat yields one height on height_o, shown for one cycle with done_o
//   high; done_o and height_o are both registered and the height is valid
//   while done_o is high.
//   Throughput is one beat per clock; latency is set by the corner hash,
//   which runs four multiplier stages after the coordinate scaling, followed
//   by four interpolation and scaling stages.
//   Results leave in input order and the receiver cannot hold them off.
//   Registers (seed, frequency, base level, amplitude) sit on the APB-style
//   port at byte addresses 0, 4, 8, 12; the user must write them only while
//   no beat is in flight (the block does not enforce it). Reset clears the
//   in-flight valid bits, loads register defaults; no beat is lost at reset release.
// ----------------------------------------------------------------------------
module value_noise_2d_height #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vn2h_pkg::CoordW-1:0]  pos_x_i,
  input  logic signed [vn2h_pkg::CoordW-1:0]  pos_z_i,
  // result channel
  output logic                                done_o,
  output logic signed [vn2h_pkg::HeightW-1:0] height_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [vn2h_pkg::AddrW-1:0]   paddr,
  input  logic        [vn2h_pkg::DataW-1:0]   pwdata,
  output logic        [vn2h_pkg::DataW-1:0]   prdata,
  output logic                                pready
);
  import vn2h_pkg::*;

  localparam int Depth = 9;

  logic [31:0]        seed_q;
  logic [FreqW-1:0]   freq_q;
  logic [HeightW-1:0] base_q;
  logic [AmpW-1:0]    amp_q;
  reg_idx_e           reg_idx;
  logic               wr_en;
  logic [Depth-1:0]   vld_d, vld_q;
  logic [31:0]        cell_x, cell_z;
  logic [WeightW-1:0] sx, sz;
  corners_t           corners;
  logic [HeightW-1:0] height;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedRst;
      freq_q <= FreqRst;
      base_q <= BaseRst;
      amp_q  <= AmpRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSeed: seed_q <= pwdata;
        RegFreq: freq_q <= pwdata[FreqW-1:0];
        RegBase: base_q <= pwdata;
        RegAmp:  amp_q  <= pwdata[AmpW-1:0];
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      RegSeed: prdata = seed_q;
      RegFreq: prdata = DataW'(freq_q);
      RegBase: prdata = base_q;
      RegAmp:  prdata = DataW'(amp_q);
    endcase
  end

  // valid bits travel with the pipeline
  assign busy  = 1'b0;
  assign vld_d = {vld_q[Depth-2:0], start && !busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // coordinate split per axis
  vn2h_coord #(
    .FRAC_BITS (FRAC_BITS)
  ) u_coord_x (
    .clk_i    (clk_i),
    .pos_i    (pos_x_i),
    .freq_i   (freq_q),
    .cell_o   (cell_x),
    .weight_o (sx)
  );

  vn2h_coord #(
    .FRAC_BITS (FRAC_BITS)
  ) u_coord_z (
    .clk_i    (clk_i),
    .pos_i    (pos_z_i),
    .freq_i   (freq_q),
    .cell_o   (cell_z),
    .weight_o (sz)
  );

  // corner hashing
  vn2h_hash u_hash (
    .clk_i     (clk_i),
    .cell_x_i  (cell_x),
    .cell_z_i  (cell_z),
    .seed_i    (seed_q),
    .corners_o (corners)
  );

  // interpolation and output register
  vn2h_interp u_interp (
    .clk_i     (clk_i),
    .corners_i (corners),
    .sx_i      (sx),
    .sz_i      (sz),
    .base_i    ($signed(base_q)),
    .amp_i     (amp_q),
    .height_o  (height)
  );

  assign done_o   = vld_q[Depth-1];
  assign height_o = $signed(height);

`ifndef SYNTH
  // every accepted beat gives a result after the pipeline depth
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##9 done_o)
    else $error("accepted beat produced no result");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##9 !done_o)
    else $error("result without an accepted beat");

  // frequency write lands in the register
  a_freq_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && reg_idx == RegFreq) |=> (freq_q == $past(pwdata[FreqW-1:0])))
    else $error("frequency write lost");
`endif

endmodule

// File: src/vn2h_coord.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2h_coord: coordinate split and smoothstep weight
// Scales one coordinate by the frequency, splits it into a lattice cell and a
// fraction, and shapes the fraction with smoothstep over two more stages.
// ----------------------------------------------------------------------------
module vn2h_coord #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic signed [vn2h_pkg::CoordW-1:0]  pos_i,
  input  logic        [vn2h_pkg::FreqW-1:0]   freq_i,
  output logic        [31:0]                  cell_o,
  output logic        [vn2h_pkg::WeightW-1:0] weight_o
);
  import vn2h_pkg::*;

  localparam int ProdW  = CoordW + FreqW + 1;
  localparam int ShiftW = FRAC_BITS + WeightW;
  localparam int SqW    = 2 * WeightW;
  localparam int SmW    = SqW + 18;

  logic signed [ProdW-1:0]   n_d, n_q;
  logic signed [ProdW-1:0]   cell_full;
  logic        [WeightW-1:0] t_d, t_q;
  logic        [SqW-1:0]     t2_d, t2_q;
  logic        [17:0]        w_d;
  logic        [SmW-1:0]     sm_d;
  logic        [WeightW-1:0] s_q;

  // stage 1: scale by frequency
  assign n_d = ProdW'(pos_i) * ProdW'($signed({1'b0, freq_i}));

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
  end

  // lattice cell by floor shift, fraction truncated to 16 bits
  assign cell_full = n_q >>> ShiftW;
  assign cell_o    = cell_full[31:0];
  assign t_d       = n_q[FRAC_BITS +: WeightW];
  assign t2_d      = SqW'(t_d) * SqW'(t_d);

  // stage 2: square of the fraction
  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    t2_q <= t2_d;
  end

  // stage 3: t^2 * (3 - 2t)
  assign w_d  = SmoothK - {1'b0, t_q, 1'b0};
  assign sm_d = SmW'(t2_q) * SmW'(w_d);

  always_ff @(posedge clk_i) begin
    s_q <= sm_d[SqW +: WeightW];
  end

  assign weight_o = s_q;

endmodule

// File: src/vn2h_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2h_hash: seeded corner hash
// Mixes the two x and two z lattice indexes, combines them with the seed for
// the four cell corners and mixes again; one multiply per stage.
// ----------------------------------------------------------------------------
module vn2h_hash (
  input  logic                     clk_i,
  input  logic [31:0]              cell_x_i,
  input  logic [31:0]              cell_z_i,
  input  logic [31:0]              seed_i,
  output vn2h_pkg::corners_t       corners_o
);
  import vn2h_pkg::*;

  logic [31:0] in_d [4];
  logic [31:0] a_d  [4];
  logic [31:0] a_q  [4];
  logic [31:0] b_d  [4];
  logic [31:0] b_q  [4];
  logic [31:0] ax   [4];
  logic [31:0] m_d  [4];
  logic [31:0] ca_d [4];
  logic [31:0] ca_q [4];
  logic [31:0] cb_d [4];
  logic [31:0] cb_q [4];

  // axis indexes: x, x+1, z, z+1 with their offsets
  always_comb begin
    in_d[0] = cell_x_i + OfsX;
    in_d[1] = cell_x_i + 32'd1 + OfsX;
    in_d[2] = cell_z_i + OfsZ;
    in_d[3] = cell_z_i + 32'd1 + OfsZ;
    for (int i = 0; i < 4; i++) begin
      a_d[i] = xs16(in_d[i]) * MixA;
      b_d[i] = xs15(a_q[i]) * MixB;
      ax[i]  = xs16(b_q[i]);
    end
  end

  // corner combine: 00, 10, 01, 11
  always_comb begin
    m_d[0] = seed_i ^ ax[0] ^ ax[2];
    m_d[1] = seed_i ^ ax[1] ^ ax[2];
    m_d[2] = seed_i ^ ax[0] ^ ax[3];
    m_d[3] = seed_i ^ ax[1] ^ ax[3];
    for (int k = 0; k < 4; k++) begin
      ca_d[k] = xs16(m_d[k]) * MixA;
      cb_d[k] = xs15(ca_q[k]) * MixB;
    end
  end

  // four mixer stages
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      a_q[i]  <= a_d[i];
      b_q[i]  <= b_d[i];
      ca_q[i] <= ca_d[i];
      cb_q[i] <= cb_d[i];
    end
  end

  // final shift and re-centering
  assign corners_o.c00 = corner_val(xs16(cb_q[0]));
  assign corners_o.c10 = corner_val(xs16(cb_q[1]));
  assign corners_o.c01 = corner_val(xs16(cb_q[2]));
  assign corners_o.c11 = corner_val(xs16(cb_q[3]));

endmodule

// File: src/vn2h_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2h_interp: bilinear interpolation, scaling and saturation
// Lerps along x then z, scales by amplitude, adds the base level and
// saturates to 32 bits; at most one multiply per stage.
// ----------------------------------------------------------------------------
module vn2h_interp (
  input  logic                                clk_i,
  input  vn2h_pkg::corners_t                  corners_i,
  input  logic        [vn2h_pkg::WeightW-1:0] sx_i,
  input  logic        [vn2h_pkg::WeightW-1:0] sz_i,
  input  logic signed [vn2h_pkg::HeightW-1:0] base_i,
  input  logic        [vn2h_pkg::AmpW-1:0]    amp_i,
  output logic        [vn2h_pkg::HeightW-1:0] height_o
);
  import vn2h_pkg::*;

  localparam int DiffW = CornerW + 1;
  localparam int LerpW = DiffW + WeightW + 1;
  localparam int ScW   = CornerW + AmpW + 1;
  localparam int SumW  = HeightW + 2;

  logic        [WeightW-1:0] sx_q1, sx_q2;
  logic        [WeightW-1:0] sz_q1, sz_q2, sz_q3;
  logic signed [CornerW-1:0] c00, c10, c01, c11;
  logic signed [DiffW-1:0]   d0, d1, dz;
  logic signed [LerpW-1:0]   p0_d, p1_d, p0_q, p1_q, p0_s, p1_s;
  logic signed [CornerW-1:0] a0_q, a1_q;
  logic signed [CornerW-1:0] hx0, hx1, hx0_q;
  logic signed [LerpW-1:0]   pz_d, pz_q, pz_s;
  logic signed [CornerW-1:0] v_d;
  logic signed [ScW-1:0]     r_d, r_q, r_s;
  logic signed [SumW-1:0]    sum_d;
  logic        [HeightW-1:0] sat_d, height_q;

  // weight delays to meet the corner values
  always_ff @(posedge clk_i) begin
    sx_q1 <= sx_i;
    sx_q2 <= sx_q1;
    sz_q1 <= sz_i;
    sz_q2 <= sz_q1;
    sz_q3 <= sz_q2;
  end

  // stage 1: x differences times x weight
  assign c00  = $signed(corners_i.c00);
  assign c10  = $signed(corners_i.c10);
  assign c01  = $signed(corners_i.c01);
  assign c11  = $signed(corners_i.c11);
  assign d0   = DiffW'(c10) - DiffW'(c00);
  assign d1   = DiffW'(c11) - DiffW'(c01);
  assign p0_d = LerpW'(d0) * LerpW'($signed({1'b0, sx_q2}));
  assign p1_d = LerpW'(d1) * LerpW'($signed({1'b0, sx_q2}));

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    p1_q <= p1_d;
    a0_q <= c00;
    a1_q <= c01;
  end

  // stage 2: finish x lerps, z difference times z weight
  assign p0_s = p0_q >>> WeightW;
  assign p1_s = p1_q >>> WeightW;
  assign hx0  = a0_q + p0_s[CornerW-1:0];
  assign hx1  = a1_q + p1_s[CornerW-1:0];
  assign dz   = DiffW'(hx1) - DiffW'(hx0);
  assign pz_d = LerpW'(dz) * LerpW'($signed({1'b0, sz_q3}));

  always_ff @(posedge clk_i) begin
    pz_q  <= pz_d;
    hx0_q <= hx0;
  end

  // stage 3: finish z lerp, scale by amplitude
  assign pz_s = pz_q >>> WeightW;
  assign v_d  = hx0_q + pz_s[CornerW-1:0];
  assign r_d  = ScW'(v_d) * ScW'($signed({1'b0, amp_i}));

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  // stage 4: add base level and saturate
  assign r_s   = r_q >>> (CornerW - 1);
  assign sum_d = SumW'(base_i) + SumW'($signed(r_s[HeightW:0]));

  always_comb begin
    priority if (sum_d[SumW-1] == 1'b0 && sum_d[SumW-2:HeightW-1] != '0) begin
      sat_d = HeightMax;
    end else if (sum_d[SumW-1] == 1'b1 && sum_d[SumW-2:HeightW-1] != '1) begin
      sat_d = HeightMin;
    end else begin
      sat_d = sum_d[HeightW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    height_q <= sat_d;
  end

  assign height_o = height_q;

endmodule
